// ----- hdl/xtea_block_cipher_unit_defines.svh -----
// Assertion macros shared by the XTEA cipher unit's checker.
`ifndef XTEA_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define XTEA_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define XTEA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hdl/xtea_pkg.sv -----
// Types, constants and the mixing function of the XTEA cipher unit.
`default_nettype none

package xtea_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ROUND_W = 7;
    localparam int unsigned CFG_W   = 3;

    localparam logic [WORD_W-1:0]  XTEA_DELTA    = 32'h9E37_79B9;
    localparam logic [ROUND_W-1:0] ROUNDS_RESET  = 7'd32;

    // Configuration register indexes.
    localparam logic [CFG_W-1:0] REG_KEY0   = 3'd0;
    localparam logic [CFG_W-1:0] REG_KEY1   = 3'd1;
    localparam logic [CFG_W-1:0] REG_KEY2   = 3'd2;
    localparam logic [CFG_W-1:0] REG_KEY3   = 3'd3;
    localparam logic [CFG_W-1:0] REG_ROUNDS = 3'd4;

    // Request types.
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } xtea_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rounds_done;
    } xtea_stat_t;

    function automatic word_t mix(input word_t v);
        mix = ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/xtea_ctrl.sv -----
// Controller of the XTEA cipher unit: sequencing and the output handshake.
`default_nettype none

module xtea_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire xtea_pkg::xtea_stat_t stat,
    output xtea_pkg::xtea_cmd_t      cmd
);
    import xtea_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (stat.rounds_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_DONE:
            begin
                // The finished block moves to the output register once it is free.
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- hdl/xtea_dpath.sv -----
// Datapath of the XTEA cipher unit: key and round registers, round unit, result word.
`default_nettype none

module xtea_dpath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [xtea_pkg::CFG_W-1:0]   cfg_index,
    input  wire logic [xtea_pkg::WORD_W-1:0]  cfg_data,
    input  wire logic                         req_type,
    input  wire logic [xtea_pkg::WORD_W-1:0]  block_low,
    input  wire logic [xtea_pkg::WORD_W-1:0]  block_high,
    input  wire xtea_pkg::xtea_cmd_t          cmd,
    output xtea_pkg::xtea_stat_t              stat,
    output logic [xtea_pkg::WORD_W-1:0]       result_low,
    output logic [xtea_pkg::WORD_W-1:0]       result_high
);
    import xtea_pkg::*;

    word_t [3:0]        key_reg;
    logic [ROUND_W-1:0] rounds_reg;

    word_t              v0_reg, v0_next;
    word_t              v1_reg, v1_next;
    word_t              sum_reg, sum_next;
    logic [ROUND_W-1:0] count_reg;
    logic               mode_reg;
    word_t              res_low_reg, res_high_reg;

    word_t              sum_init;
    word_t              sum_step;

    // Decryption starts from delta times the round count, modulo 2^32.
    assign sum_init = XTEA_DELTA * word_t'(rounds_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            rounds_reg <= ROUNDS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY0:   key_reg[0] <= cfg_data;
                REG_KEY1:   key_reg[1] <= cfg_data;
                REG_KEY2:   key_reg[2] <= cfg_data;
                REG_KEY3:   key_reg[3] <= cfg_data;
                REG_ROUNDS: rounds_reg <= cfg_data[ROUND_W-1:0];
                default:    ;
            endcase
        end
    end

    // One full cycle of the cipher: both halves are updated together in one step.
    always_comb
    begin
        sum_step = '0;
        v0_next  = v0_reg;
        v1_next  = v1_reg;
        if (mode_reg == REQ_ENCRYPT)
        begin
            sum_step = sum_reg + XTEA_DELTA;
            v0_next  = v0_reg + (mix(v1_reg) ^ (sum_reg + key_reg[sum_reg[1:0]]));
            v1_next  = v1_reg + (mix(v0_next) ^ (sum_step + key_reg[sum_step[12:11]]));
        end
        else
        begin
            sum_step = sum_reg - XTEA_DELTA;
            v1_next  = v1_reg - (mix(v0_reg) ^ (sum_reg + key_reg[sum_reg[12:11]]));
            v0_next  = v0_reg - (mix(v1_next) ^ (sum_step + key_reg[sum_step[1:0]]));
        end
        sum_next = sum_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            count_reg <= rounds_reg;
        end
        else if (cmd.step)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v0_reg   <= block_low;
            v1_reg   <= block_high;
            mode_reg <= req_type;
            sum_reg  <= (req_type == REQ_DECRYPT) ? sum_init : '0;
        end
        else if (cmd.step)
        begin
            v0_reg  <= v0_next;
            v1_reg  <= v1_next;
            sum_reg <= sum_next;
        end
        if (cmd.emit)
        begin
            res_low_reg  <= v0_reg;
            res_high_reg <= v1_reg;
        end
    end

    assign stat.rounds_done = (count_reg == '0);
    assign result_low       = res_low_reg;
    assign result_high      = res_high_reg;

endmodule

`default_nettype wire

// ----- hdl/xtea_block_cipher_unit.sv -----
// The round unit does one full XTEA cycle per clock on one block, and a new block
// is taken only once the last one has moved to the output register.
// The finished result waits in an output register while the next block runs.
// Reset clears the key to zero, sets 32 rounds and empties the unit and output.
// Top level of the XTEA cipher unit: controller, datapath and configuration port.
`default_nettype none

module xtea_block_cipher_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [xtea_pkg::CFG_W-1:0]   cfg_index,
    input  wire logic [xtea_pkg::WORD_W-1:0]  cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         req_type,
    input  wire logic [xtea_pkg::WORD_W-1:0]  block_low,
    input  wire logic [xtea_pkg::WORD_W-1:0]  block_high,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [xtea_pkg::WORD_W-1:0]       result_low,
    output logic [xtea_pkg::WORD_W-1:0]       result_high
);
    import xtea_pkg::*;

    xtea_cmd_t  cmd;
    xtea_stat_t stat;

    // Always taken; user must send cfg words only while the unit is idle; unchecked.
    assign cfg_ready = 1'b1;

    xtea_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    xtea_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .block_low   (block_low),
        .block_high  (block_high),
        .cmd         (cmd),
        .stat        (stat),
        .result_low  (result_low),
        .result_high (result_high)
    );

endmodule

`default_nettype wire

// ----- hdl/xtea_checker.sv -----
// Port-level checker of the XTEA cipher unit and its bind to the top level.
`default_nettype none

`include "xtea_block_cipher_unit_defines.svh"

module xtea_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] result_low,
    input wire logic [31:0] result_high
);

    `XTEA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
    `XTEA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(result_low) && $stable(result_high), "stalled result word changed")
    `XTEA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "new block taken while one is in work")
    `XTEA_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result word appeared too early")

endmodule

bind xtea_block_cipher_unit xtea_checker u_xtea_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_low  (result_low),
    .result_high (result_high)
);

`default_nettype wire

// ----- tb/xtea_block_cipher_unit_checker.sv -----
// Predicts every result of the XTEA cipher unit from the watched channels and checks it.
`timescale 1ns / 1ps

module xtea_block_cipher_unit_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    input  wire logic                         cfg_ready,
    input  wire logic [xtea_pkg::CFG_W-1:0]   cfg_index,
    input  wire logic [xtea_pkg::WORD_W-1:0]  cfg_data,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic                         req_type,
    input  wire logic [xtea_pkg::WORD_W-1:0]  block_low,
    input  wire logic [xtea_pkg::WORD_W-1:0]  block_high,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic [xtea_pkg::WORD_W-1:0]  result_low,
    input  wire logic [xtea_pkg::WORD_W-1:0]  result_high,
    output int                                mismatch_count,
    output int                                blocks_in_flight
);

    typedef struct packed {
        xtea_pkg::word_t low;
        xtea_pkg::word_t high;
    } cipher_block_t;

    xtea_pkg::word_t                  key_copy [4];
    logic [xtea_pkg::ROUND_W-1:0]     rounds_copy;
    cipher_block_t                    awaited_blocks [$];

    function automatic xtea_pkg::word_t shift_fold(input xtea_pkg::word_t v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    // Runs the whole cipher on one block with the key and round count held here.
    function automatic cipher_block_t xtea_process_block(input logic req,
                                                        input cipher_block_t blk);
        xtea_pkg::word_t v0;
        xtea_pkg::word_t v1;
        xtea_pkg::word_t sum;
        cipher_block_t   res;
        v0 = blk.low;
        v1 = blk.high;
        if (req == xtea_pkg::REQ_ENCRYPT)
        begin
            sum = '0;
            for (int n = 0; n < rounds_copy; n++)
            begin
                v0  = v0 + (shift_fold(v1) ^ (sum + key_copy[sum[1:0]]));
                sum = sum + xtea_pkg::XTEA_DELTA;
                v1  = v1 + (shift_fold(v0) ^ (sum + key_copy[sum[12:11]]));
            end
        end
        else
        begin
            // Decryption starts where encryption with the same count ends.
            sum = xtea_pkg::XTEA_DELTA * xtea_pkg::word_t'(rounds_copy);
            for (int n = 0; n < rounds_copy; n++)
            begin
                v1  = v1 - (shift_fold(v0) ^ (sum + key_copy[sum[12:11]]));
                sum = sum - xtea_pkg::XTEA_DELTA;
                v0  = v0 - (shift_fold(v1) ^ (sum + key_copy[sum[1:0]]));
            end
        end
        res.low  = v0;
        res.high = v1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int            bad;
        cipher_block_t want;
        cipher_block_t given;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_copy[i] = '0;
            rounds_copy = xtea_pkg::ROUNDS_RESET;
            awaited_blocks.delete();
            mismatch_count   <= 0;
            blocks_in_flight <= 0;
        end
        else
        begin
            bad = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    xtea_pkg::REG_KEY0,
                    xtea_pkg::REG_KEY1,
                    xtea_pkg::REG_KEY2,
                    xtea_pkg::REG_KEY3:   key_copy[cfg_index[1:0]] = cfg_data;
                    xtea_pkg::REG_ROUNDS: rounds_copy = cfg_data[xtea_pkg::ROUND_W-1:0];
                    default: ;
                endcase
            end
            // A result can never belong to a word taken at the same edge.
            if (out_valid && out_ready)
            begin
                if (awaited_blocks.size() == 0)
                begin
                    $display("%0t: result with none expected: expected none, actual %h %h",
                             $time, result_low, result_high);
                    bad++;
                end
                else
                begin
                    want = awaited_blocks.pop_front();
                    if (result_low !== want.low)
                    begin
                        $display("%0t: result_low expected %h actual %h",
                                 $time, want.low, result_low);
                        bad++;
                    end
                    if (result_high !== want.high)
                    begin
                        $display("%0t: result_high expected %h actual %h",
                                 $time, want.high, result_high);
                        bad++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                given.low  = block_low;
                given.high = block_high;
                awaited_blocks.push_back(xtea_process_block(req_type, given));
            end
            mismatch_count   <= mismatch_count + bad;
            blocks_in_flight <= awaited_blocks.size();
        end
    end

endmodule

// ----- tb/xtea_block_cipher_unit_tb.sv -----
// Drives the XTEA cipher unit with directed and random blocks and key settings.
`timescale 1ns / 1ps

module xtea_block_cipher_unit_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int BLOCK_TARGET = 450;
    localparam int DRAIN_CYCLES = 160;

    localparam logic [xtea_pkg::CFG_W-1:0] UNMAPPED_FIRST = xtea_pkg::REG_ROUNDS + 1'b1;
    localparam logic [xtea_pkg::CFG_W-1:0] UNMAPPED_LAST  = '1;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    cfg_valid   = 1'b0;
    logic [xtea_pkg::CFG_W-1:0] cfg_index = '0;
    xtea_pkg::word_t         cfg_data    = '0;
    logic                    in_valid    = 1'b0;
    logic                    req_type    = xtea_pkg::REQ_ENCRYPT;
    xtea_pkg::word_t         block_low   = '0;
    xtea_pkg::word_t         block_high  = '0;
    logic                    out_ready   = 1'b0;
    logic                    cfg_ready;
    logic                    in_ready;
    logic                    out_valid;
    xtea_pkg::word_t         result_low;
    xtea_pkg::word_t         result_high;

    int mismatch_count;
    int blocks_in_flight;
    int cycle_count = 0;
    int blocks_sent = 0;
    bit quiet_gaps  = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    xtea_block_cipher_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .block_low   (block_low),
        .block_high  (block_high),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_low  (result_low),
        .result_high (result_high)
    );

    xtea_block_cipher_unit_checker scoreboard (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .block_low        (block_low),
        .block_high       (block_high),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_low       (result_low),
        .result_high      (result_high),
        .mismatch_count   (mismatch_count),
        .blocks_in_flight (blocks_in_flight)
    );

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("xtea_block_cipher_unit: mismatch");
        $finish;
    end

    function automatic int unsigned draw_gap();
        if (quiet_gaps || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // Mostly random halves, with all-zero, all-one and one-hot values mixed in.
    function automatic xtea_pkg::word_t draw_half();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return xtea_pkg::word_t'(1) << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic draw_req();
        return $urandom_range(0, 1) ? xtea_pkg::REQ_DECRYPT : xtea_pkg::REQ_ENCRYPT;
    endfunction

    // This task lowers valid only when a gap is drawn, so back-to-back words keep it high.
    task automatic send_block(input logic req, input xtea_pkg::word_t lo,
                              input xtea_pkg::word_t hi);
        int unsigned hold;
        hold = draw_gap();
        if (hold != 0)
        begin
            in_valid <= 1'b0;
            repeat (hold) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        block_low  <= lo;
        block_high <= hi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        blocks_sent++;
    endtask

    task automatic write_reg(input logic [xtea_pkg::CFG_W-1:0] idx,
                             input xtea_pkg::word_t data);
        int unsigned hold;
        hold = draw_gap();
        if (hold != 0)
        begin
            cfg_valid <= 1'b0;
            repeat (hold) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // The round count sits in the low bits; the upper bits are noise the unit drops.
    task automatic write_rounds(input logic [xtea_pkg::ROUND_W-1:0] rounds);
        xtea_pkg::word_t data;
        data = $urandom;
        data[xtea_pkg::ROUND_W-1:0] = rounds;
        write_reg(xtea_pkg::REG_ROUNDS, data);
    endtask

    task automatic write_key(input xtea_pkg::word_t k0, input xtea_pkg::word_t k1,
                             input xtea_pkg::word_t k2, input xtea_pkg::word_t k3);
        write_reg(xtea_pkg::REG_KEY0, k0);
        write_reg(xtea_pkg::REG_KEY1, k1);
        write_reg(xtea_pkg::REG_KEY2, k2);
        write_reg(xtea_pkg::REG_KEY3, k3);
    endtask

    // Drops both valids and waits until every result has come back.
    task automatic settle();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        do
            @(posedge clk);
        while (blocks_in_flight != 0);
    endtask

    task automatic send_pair_random();
        send_block(xtea_pkg::REQ_ENCRYPT, draw_half(), draw_half());
        send_block(xtea_pkg::REQ_DECRYPT, draw_half(), draw_half());
    endtask

    initial
    begin : result_sink
        int unsigned hold;
        wait (rst_n);
        forever
        begin
            hold = draw_gap();
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int                          phase_len;
        int unsigned                 pick;
        logic [xtea_pkg::ROUND_W-1:0] rounds;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset key of all zeros and the default round count.
        send_block(xtea_pkg::REQ_ENCRYPT, '0, '0);
        send_block(xtea_pkg::REQ_DECRYPT, '0, '0);
        send_block(xtea_pkg::REQ_ENCRYPT, '1, '1);
        send_block(xtea_pkg::REQ_DECRYPT, '1, '1);
        settle();

        write_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
        write_rounds(7'd32);
        settle();
        send_block(xtea_pkg::REQ_ENCRYPT, 32'h4142_4344, 32'h4546_4748);
        send_block(xtea_pkg::REQ_DECRYPT, 32'h4142_4344, 32'h4546_4748);
        settle();

        // Writes above the round count register must leave the setup alone.
        for (int idx = UNMAPPED_FIRST; idx <= UNMAPPED_LAST; idx++)
            write_reg(idx[xtea_pkg::CFG_W-1:0], '1);
        settle();
        send_block(xtea_pkg::REQ_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(xtea_pkg::REQ_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        settle();

        // Zero rounds pass the block through; counts past sixty-four still run.
        write_rounds(7'd0);
        settle();
        send_pair_random();
        settle();
        write_rounds(7'd1);
        settle();
        send_pair_random();
        settle();
        write_rounds(7'd64);
        settle();
        send_pair_random();
        settle();
        write_rounds(7'd127);
        settle();
        send_pair_random();
        settle();
        write_rounds(7'd65);
        settle();
        send_pair_random();
        settle();

        write_key('1, '1, '1, '1);
        write_rounds(7'd32);
        settle();
        send_block(xtea_pkg::REQ_ENCRYPT, '0, '0);
        send_block(xtea_pkg::REQ_DECRYPT, '1, '1);
        send_pair_random();
        settle();

        while (blocks_sent < BLOCK_TARGET)
        begin
            quiet_gaps = ($urandom_range(0, 4) == 0);
            for (int idx = 0; idx <= xtea_pkg::REG_KEY3; idx++)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    pick = $urandom_range(0, 7);
                    write_reg(idx[xtea_pkg::CFG_W-1:0],
                              pick == 0 ? '0 : (pick == 1 ? '1 : xtea_pkg::word_t'($urandom)));
                end
            end
            pick = $urandom_range(0, 19);
            if (pick == 0)
                rounds = 7'd0;
            else if (pick == 1)
                rounds = 7'd64;
            else if (pick == 2)
                rounds = 7'($urandom_range(65, 127));
            else
                rounds = 7'($urandom_range(1, 40));
            write_rounds(rounds);
            if ($urandom_range(0, 5) == 0)
                write_reg(3'($urandom_range(UNMAPPED_FIRST, UNMAPPED_LAST)), $urandom);
            settle();

            // Long round counts are slow, so those phases stay short.
            phase_len = (rounds > 7'd64) ? $urandom_range(2, 4) : $urandom_range(8, 30);
            repeat (phase_len)
                send_block(draw_req(), draw_half(), draw_half());
            settle();
        end

        quiet_gaps = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && blocks_in_flight == 0)
            $display("xtea_block_cipher_unit: match");
        else
            $display("xtea_block_cipher_unit: mismatch");
        $finish;
    end

endmodule
